### rtl/hns_pkg.sv
`timescale 1ns / 1ps
package hns_pkg;

  // height scale of the edge vectors
  localparam int HSCALE = 255;
  // normal sum component, square, squared length, search accumulator
  localparam int S_W   = 11;
  localparam int SQ_W  = 20;
  localparam int LEN_W = 22;
  localparam int ACC_W = 58;
  localparam int Q_W   = 16;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } opcode_t;

  // register select, taken from paddr[2]
  localparam logic REG_ROW_LENGTH = 1'b0;
  localparam logic REG_ROW_COUNT  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_NEIGH,
    ST_SQUARE,
    ST_LENGTH,
    ST_ITER,
    ST_OUT
  } hns_state_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] height;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [9:0]         row_index;
    logic [9:0]         column_index;
    logic               frame_last;
  } out_item_t;

  typedef struct packed {
    logic       load_item;
    logic       wr_row0;
    logic       capture;
    logic       compute;
    logic       square;
    logic       length;
    logic       iter_en;
    logic [3:0] iter_k;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic       last_col;
    logic       hu;
    logic       drain;
    logic [9:0] row_idx;
    logic       frame_last;
  } item_info_t;

  // sign and magnitude back to Q1.15
  function automatic logic [15:0] q15_out(input logic signed [S_W-1:0] s,
                                          input logic [Q_W-1:0] q);
    logic [15:0] r;
    if (s == '0) begin
      r = '0;
    end else if (!s[S_W-1]) begin
      r = (q > 16'd32767) ? 16'd32767 : q;
    end else begin
      r = 16'd0 - q;
    end
    return r;
  endfunction

endpackage

### rtl/hns_quant.sv
`timescale 1ns / 1ps
// Bit-serial search for the largest q with (2q-1)^2 * len <= m2 * 2^32.
// e_acc holds (2q)^2*len and f_acc holds 2q*len for the bits found so far.
module hns_quant (
  input  logic                        clk,
  input  logic                        start,
  input  logic                        step_en,
  input  logic [3:0]                  k,
  input  logic [hns_pkg::LEN_W-1:0]   len,
  input  logic [hns_pkg::SQ_W-1:0]    m2,
  output logic [hns_pkg::Q_W-1:0]     q
);

  logic [hns_pkg::ACC_W-1:0] e_acc;
  logic [hns_pkg::ACC_W-1:0] f_acc;
  logic [hns_pkg::ACC_W-1:0] len_x;
  logic [hns_pkg::ACC_W-1:0] rhs;
  logic [hns_pkg::ACC_W-1:0] f_s2;
  logic [hns_pkg::ACC_W-1:0] len_s1;
  logic [hns_pkg::ACC_W-1:0] len_s2;
  logic [hns_pkg::ACC_W-1:0] len_sq;
  logic [hns_pkg::ACC_W-1:0] t_val;
  logic [5:0]                sh1;
  logic [5:0]                sh2;
  logic [5:0]                sh4;

  always_comb begin
    sh1    = {2'b00, k} + 6'd1;
    sh2    = {2'b00, k} + 6'd2;
    sh4    = {1'b0, k, 1'b0} + 6'd2;
    len_x  = hns_pkg::ACC_W'(len);
    rhs    = hns_pkg::ACC_W'(m2) << 32;
    f_s2   = f_acc << sh2;
    len_s1 = len_x << sh1;
    len_s2 = len_x << sh2;
    len_sq = len_x << sh4;
    // candidate q + 2^k, s = 2^(k+1): E + 2F(s-1) + (s-1)^2 len
    t_val  = e_acc + f_s2 - (f_acc << 1) + len_sq - len_s2 + len_x;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      e_acc <= '0;
      f_acc <= '0;
      q     <= '0;
    end else if (step_en && (t_val <= rhs)) begin
      q[k]  <= 1'b1;
      e_acc <= e_acc + f_s2 + len_sq;
      f_acc <= f_acc + len_s1;
    end
  end

endmodule

### rtl/hns_datapath.sv
`timescale 1ns / 1ps
module hns_datapath #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  hns_pkg::dp_cmd_t              cmd,
  input  hns_pkg::item_info_t           info,
  input  logic [$clog2(MAX_WIDTH)-1:0]  col,
  input  logic [7:0]                    height,
  input  logic                          nrm_stall,
  output logic                          nrm_valid,
  output hns_pkg::out_item_t            nrm,
  output logic                          out_free
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int S_W   = hns_pkg::S_W;

  logic [7:0] upper_mem  [MAX_WIDTH];
  logic [7:0] middle_mem [MAX_WIDTH];
  logic [7:0] upper_q;
  logic [7:0] mid_q;

  hns_pkg::item_info_t info_l;
  logic [COL_W-1:0]    col_l;
  logic [7:0]          hv_l;
  logic [7:0]          center;
  logic [7:0]          up;
  logic [7:0]          left_reg;
  logic signed [8:0]   prior_e;

  logic [COL_W-1:0] right_addr;
  logic [COL_W-1:0] mid_rd_addr;
  logic [COL_W-1:0] mid_wr_addr;
  logic [7:0]       mid_wr_data;
  logic             mid_we;
  logic             up_we;

  always_comb begin
    right_addr  = info_l.last_col ? col_l : col_l + COL_W'(1);
    mid_rd_addr = cmd.capture ? right_addr : col;
    up_we       = cmd.capture && !info_l.drain;
    mid_we      = cmd.wr_row0 || up_we;
    mid_wr_addr = cmd.wr_row0 ? col : col_l;
    mid_wr_data = cmd.wr_row0 ? height : hv_l;
  end

  always_ff @(posedge clk) begin
    if (up_we) begin
      upper_mem[col_l] <= mid_q;
    end
    if (cmd.load_item) begin
      upper_q <= upper_mem[col];
    end
  end

  always_ff @(posedge clk) begin
    if (mid_we) begin
      middle_mem[mid_wr_addr] <= mid_wr_data;
    end
    if (cmd.load_item || cmd.capture) begin
      mid_q <= middle_mem[mid_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      info_l <= info;
      col_l  <= col;
      hv_l   <= height;
    end
    if (cmd.capture) begin
      center <= mid_q;
      up     <= upper_q;
    end
  end

  // edge differences and neighbor presence
  logic signed [8:0]     du, dl, dd, er, ee;
  logic signed [S_W-1:0] dl_x, dd_x, du_x, ee_x;
  logic                  hl, hd, hr;
  logic                  pa, pb, pc, pd;
  logic [2:0]            cnt;
  logic signed [S_W-1:0] sx_n, sy_n, sz_n;
  logic signed [S_W-1:0] sx, sy, sz;

  always_comb begin
    du   = $signed({1'b0, up})       - $signed({1'b0, center});
    dl   = $signed({1'b0, left_reg}) - $signed({1'b0, center});
    dd   = $signed({1'b0, hv_l})     - $signed({1'b0, center});
    er   = $signed({1'b0, mid_q})    - $signed({1'b0, center});
    ee   = info_l.last_col ? prior_e : er;
    du_x = S_W'(du);
    dl_x = S_W'(dl);
    dd_x = S_W'(dd);
    ee_x = S_W'(ee);
    hl   = (col_l != '0);
    hd   = !info_l.drain;
    hr   = !info_l.last_col || hl;
    pa   = info_l.hu && hl;
    pb   = hl && hd;
    pc   = hd && hr;
    pd   = hr && info_l.hu;
    cnt  = {2'b00, pa} + {2'b00, pb} + {2'b00, pc} + {2'b00, pd};
    sx_n = (pa ? dl_x : '0) + (pb ? dl_x : '0) - (pc ? ee_x : '0) - (pd ? ee_x : '0);
    sy_n = S_W'({cnt, 8'b0}) - S_W'(cnt);
    sz_n = (pa ? du_x : '0) + (pd ? du_x : '0) - (pb ? dd_x : '0) - (pc ? dd_x : '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.compute) begin
      sx       <= sx_n;
      sy       <= sy_n;
      sz       <= sz_n;
      left_reg <= center;
      if (!info_l.last_col) begin
        prior_e <= er;
      end
    end
  end

  logic signed [2*S_W-1:0]        px, py, pz;
  logic [hns_pkg::SQ_W-1:0]       sqx, sqy, sqz;
  logic [hns_pkg::LEN_W-1:0]      len;

  always_comb begin
    px = sx * sx;
    py = sy * sy;
    pz = sz * sz;
  end

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      sqx <= px[hns_pkg::SQ_W-1:0];
      sqy <= py[hns_pkg::SQ_W-1:0];
      sqz <= pz[hns_pkg::SQ_W-1:0];
    end
    if (cmd.length) begin
      len <= {2'b00, sqx} + {2'b00, sqy} + {2'b00, sqz};
    end
  end

  logic [hns_pkg::Q_W-1:0] qx, qy, qz;

  hns_quant u_qx (
    .clk(clk), .start(cmd.length), .step_en(cmd.iter_en), .k(cmd.iter_k),
    .len(len), .m2(sqx), .q(qx)
  );
  hns_quant u_qy (
    .clk(clk), .start(cmd.length), .step_en(cmd.iter_en), .k(cmd.iter_k),
    .len(len), .m2(sqy), .q(qy)
  );
  hns_quant u_qz (
    .clk(clk), .start(cmd.length), .step_en(cmd.iter_en), .k(cmd.iter_k),
    .len(len), .m2(sqz), .q(qz)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      nrm_valid <= 1'b0;
    end else if (cmd.out_load) begin
      nrm_valid <= 1'b1;
    end else if (!nrm_stall) begin
      nrm_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      nrm.normal_x     <= $signed(hns_pkg::q15_out(sx, qx));
      nrm.normal_y     <= $signed(hns_pkg::q15_out(sy, qy));
      nrm.normal_z     <= $signed(hns_pkg::q15_out(sz, qz));
      nrm.row_index    <= info_l.row_idx;
      nrm.column_index <= 10'(col_l);
      nrm.frame_last   <= info_l.frame_last;
    end
  end

  assign out_free = !nrm_valid || !nrm_stall;

endmodule

### rtl/hns_ctrl.sv
`timescale 1ns / 1ps
module hns_ctrl #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_ROWS  = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          restart,
  input  logic                          pix_valid,
  input  hns_pkg::opcode_t              pix_opcode,
  input  logic [$clog2(MAX_WIDTH)-1:0]  w_last,
  input  logic [$clog2(MAX_ROWS)-1:0]   h_last,
  input  logic                          out_free,
  output logic                          pix_stall,
  output hns_pkg::dp_cmd_t              cmd,
  output hns_pkg::item_info_t           info,
  output logic [$clog2(MAX_WIDTH)-1:0]  col
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_ROWS);

  hns_pkg::hns_state_t state, state_next;
  logic [COL_W-1:0]    in_col;
  logic [ROW_W-1:0]    in_row;
  logic                draining;
  logic [3:0]          iter_k;

  logic accept, is_pix, take_pix, emit_pix, emit_drain, emit, col_end;

  always_comb begin
    accept     = (state == hns_pkg::ST_IDLE) && pix_valid;
    is_pix     = (pix_opcode == hns_pkg::OP_PIXEL);
    take_pix   = accept && is_pix && !draining;
    emit_pix   = take_pix && (in_row != '0);
    emit_drain = accept && !is_pix && draining;
    emit       = emit_pix || emit_drain;
    col_end    = (in_col == w_last);
  end

  always_comb begin
    info.last_col   = col_end;
    info.hu         = draining ? (h_last != '0) : (in_row != ROW_W'(1));
    info.drain      = draining;
    info.row_idx    = draining ? 10'(h_last) : 10'(in_row - ROW_W'(1));
    info.frame_last = draining && col_end;
    col             = in_col;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      hns_pkg::ST_IDLE:   if (emit) state_next = hns_pkg::ST_READ;
      hns_pkg::ST_READ:   state_next = hns_pkg::ST_NEIGH;
      hns_pkg::ST_NEIGH:  state_next = hns_pkg::ST_SQUARE;
      hns_pkg::ST_SQUARE: state_next = hns_pkg::ST_LENGTH;
      hns_pkg::ST_LENGTH: state_next = hns_pkg::ST_ITER;
      hns_pkg::ST_ITER:   if (iter_k == '0) state_next = hns_pkg::ST_OUT;
      hns_pkg::ST_OUT:    if (out_free) state_next = hns_pkg::ST_IDLE;
      default:            state_next = hns_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.iter_k = iter_k;
    pix_stall  = 1'b1;
    unique case (state)
      hns_pkg::ST_IDLE: begin
        pix_stall     = 1'b0;
        cmd.load_item = emit;
        cmd.wr_row0   = take_pix && (in_row == '0);
      end
      hns_pkg::ST_READ:   cmd.capture = 1'b1;
      hns_pkg::ST_NEIGH:  cmd.compute = 1'b1;
      hns_pkg::ST_SQUARE: cmd.square  = 1'b1;
      hns_pkg::ST_LENGTH: cmd.length  = 1'b1;
      hns_pkg::ST_ITER:   cmd.iter_en = 1'b1;
      hns_pkg::ST_OUT:    cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hns_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iter_k <= '0;
    end else if (state == hns_pkg::ST_LENGTH) begin
      iter_k <= 4'd15;
    end else if (state == hns_pkg::ST_ITER) begin
      iter_k <= iter_k - 4'd1;
    end
  end

  // raster position; the drain walks the last row with the column counter
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_col   <= '0;
      in_row   <= '0;
      draining <= 1'b0;
    end else if (take_pix) begin
      if (col_end) begin
        in_col <= '0;
        if (in_row == h_last) begin
          in_row   <= '0;
          draining <= 1'b1;
        end else begin
          in_row <= in_row + ROW_W'(1);
        end
      end else begin
        in_col <= in_col + COL_W'(1);
      end
    end else if (emit_drain) begin
      if (col_end) begin
        in_col   <= '0;
        in_row   <= '0;
        draining <= 1'b0;
      end else begin
        in_col <= in_col + COL_W'(1);
      end
    end
  end

endmodule

### rtl/heightmap_normal_stencil.sv
`timescale 1ns / 1ps
// Heightmap normal stencil.
// pix channel: one item per pixel (opcode pixel, 8-bit height) in raster
// order, or a flush item. nrm channel: one unit normal per pixel in Q1.15
// with its row, column and a frame_last mark. Normals trail the input by
// one row; after the last pixel of a frame, send W flush items to drain the
// last row. Pixels of row 0, pixels during the drain and flushes outside
// the drain are taken without a busy period and give no item.
// An item that produces a normal holds pix_stall high through the row store
// reads, neighbor sums, squares and squared length, the shared bit-serial
// root/divide search (three lanes, one per component) and the load of the
// output register, which waits until that register is free.
// A finished item waits in the output register while nrm_stall is high;
// the next input item is taken meanwhile and its result is held until the
// register is free.
// APB registers: row_length at 0x0, row_count at 0x4, 11 bits each, reset
// 1024, clamped to 1..MAX_WIDTH and 1..MAX_ROWS. Any write restarts the
// frame. Reset (rst, synchronous) clears the frame position and the output.
// Row stores hold no reset value; every entry is written before its value is used.
module heightmap_normal_stencil #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_ROWS  = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                pix_valid,
  output logic                pix_stall,
  input  hns_pkg::in_item_t   pix,
  output logic                nrm_valid,
  input  logic                nrm_stall,
  output hns_pkg::out_item_t  nrm,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_ROWS);

  logic [10:0]      row_length;
  logic [10:0]      row_count;
  logic             cfg_wr;
  logic [COL_W-1:0] w_last;
  logic [ROW_W-1:0] h_last;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // register select by paddr[2]; any write restarts the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= 11'd1024;
      row_count  <= 11'd1024;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        hns_pkg::REG_ROW_LENGTH: row_length <= pwdata[10:0];
        hns_pkg::REG_ROW_COUNT:  row_count  <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      hns_pkg::REG_ROW_LENGTH: prdata = {21'b0, row_length};
      hns_pkg::REG_ROW_COUNT:  prdata = {21'b0, row_count};
      default:                 prdata = '0;
    endcase
  end

  // last column and last row index of the frame in use
  always_comb begin
    if (row_length == '0) begin
      w_last = '0;
    end else if (32'(row_length) > MAX_WIDTH) begin
      w_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_last = COL_W'(row_length - 11'd1);
    end
    if (row_count == '0) begin
      h_last = '0;
    end else if (32'(row_count) > MAX_ROWS) begin
      h_last = ROW_W'(MAX_ROWS - 1);
    end else begin
      h_last = ROW_W'(row_count - 11'd1);
    end
  end

  hns_pkg::dp_cmd_t    cmd;
  hns_pkg::item_info_t info;
  logic [COL_W-1:0]    col;
  logic                out_free;

  hns_ctrl #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_ROWS (MAX_ROWS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .restart   (cfg_wr),
    .pix_valid (pix_valid),
    .pix_opcode(pix.opcode),
    .w_last    (w_last),
    .h_last    (h_last),
    .out_free  (out_free),
    .pix_stall (pix_stall),
    .cmd       (cmd),
    .info      (info),
    .col       (col)
  );

  hns_datapath #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .info     (info),
    .col      (col),
    .height   (pix.height),
    .nrm_stall(nrm_stall),
    .nrm_valid(nrm_valid),
    .nrm      (nrm),
    .out_free (out_free)
  );

`ifndef NO_ASSERTIONS
  // the y sum is 255 times the count of edge pairs, never negative
  a_ny_sign: assert property (@(posedge clk) disable iff (rst)
    nrm_valid |-> !nrm.normal_y[15])
    else $error("negative normal_y");

  // no edge pair means a zero normal in all three components
  a_zero_sum: assert property (@(posedge clk) disable iff (rst)
    (nrm_valid && nrm.normal_y == 16'sd0) |->
      (nrm.normal_x == 16'sd0 && nrm.normal_z == 16'sd0))
    else $error("partial zero normal");

  // a new result only comes out of a busy period
  a_out_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(nrm_valid) |-> $past(pix_stall))
    else $error("result without a busy period");
`endif

endmodule

### test/hns_checker.sv
`timescale 1ns / 1ps
module hns_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                pix_valid,
  input  logic                pix_stall,
  input  hns_pkg::in_item_t   pix,
  input  logic                nrm_valid,
  input  logic                nrm_stall,
  input  hns_pkg::out_item_t  nrm,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic                pready,
  output int                  fail_count,
  output int                  normals_pending
);

  localparam int MAXW = 1024;
  localparam int MAXH = 1024;

  logic [7:0]         upper_line [MAXW];
  logic [7:0]         middle_line[MAXW];
  int                 right_diff_prev;
  int                 cur_row, cur_col, emit_pos;
  bit                 draining;
  logic [10:0]        row_length_reg, row_count_reg;
  hns_pkg::out_item_t normal_queue[$];

  function automatic int width_used();
    int w;
    w = row_length_reg;
    if (w < 1) w = 1;
    if (w > MAXW) w = MAXW;
    return w;
  endfunction

  function automatic int height_used();
    int h;
    h = row_count_reg;
    if (h < 1) h = 1;
    if (h > MAXH) h = MAXH;
    return h;
  endfunction

  function void restart_frame();
    cur_row = 0;
    cur_col = 0;
    emit_pos = 0;
    draining = 0;
    right_diff_prev = 0;
  endfunction

  // nearest Q1.15 by bisection on (2q-1)^2 * len <= 4 s^2 * 2^30
  function automatic logic [15:0] to_q15(longint s, longint len);
    longint unsigned m, rhs, lo, hi, mid, t;
    if (len <= 0 || s == 0) return 16'd0;
    m = (s < 0) ? -s : s;
    rhs = (m * m) << 32;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 2 * mid - 1;
      if (t * t * longint'(len) <= rhs) lo = mid;
      else hi = mid - 1;
    end
    if (s > 0) return (lo > 32767) ? 16'd32767 : 16'(lo);
    return 16'(65536 - lo);
  endfunction

  function void predict_normal(int c, int center, int up, bit hu, int left, bit hl,
                               int down, bit hd, int right);
    longint a[3], b[3], d[3], e[3], s[3], len;
    int w, h, diff;
    bit hr, last;
    hns_pkg::out_item_t o;
    w = width_used();
    h = height_used();
    a = '{0, 0, 0};
    b = '{0, 0, 0};
    d = '{0, 0, 0};
    e = '{0, 0, 0};
    if (c == 0) right_diff_prev = 0;
    if (c != w - 1) begin
      diff = right - center;
      right_diff_prev = diff;
      hr = 1;
    end else begin
      diff = right_diff_prev;
      hr = (c != 0);
    end
    if (hu) begin a[1] = up - center;   a[2] = -hns_pkg::HSCALE; end
    if (hl) begin b[0] = -hns_pkg::HSCALE; b[1] = left - center; end
    if (hd) begin d[1] = down - center; d[2] = hns_pkg::HSCALE; end
    if (hr) begin e[0] = hns_pkg::HSCALE; e[1] = diff; end
    // up x left + left x down + down x right + right x up
    s[0] = a[1]*b[2]-a[2]*b[1] + b[1]*d[2]-b[2]*d[1]
         + d[1]*e[2]-d[2]*e[1] + e[1]*a[2]-e[2]*a[1];
    s[1] = a[2]*b[0]-a[0]*b[2] + b[2]*d[0]-b[0]*d[2]
         + d[2]*e[0]-d[0]*e[2] + e[2]*a[0]-e[0]*a[2];
    s[2] = a[0]*b[1]-a[1]*b[0] + b[0]*d[1]-b[1]*d[0]
         + d[0]*e[1]-d[1]*e[0] + e[0]*a[1]-e[1]*a[0];
    for (int k = 0; k < 3; k++) s[k] = s[k] / hns_pkg::HSCALE;
    len = s[0]*s[0] + s[1]*s[1] + s[2]*s[2];
    o.normal_x = to_q15(s[0], len);
    o.normal_y = to_q15(s[1], len);
    o.normal_z = to_q15(s[2], len);
    o.row_index = 10'(emit_pos / w);
    o.column_index = 10'(c);
    last = (emit_pos == w * h - 1);
    o.frame_last = last;
    normal_queue.push_back(o);
    emit_pos++;
    if (last) restart_frame();
  endfunction

  function void take_item(hns_pkg::in_item_t it);
    int w, h, c, r, hv;
    w = width_used();
    h = height_used();
    hv = it.height;
    if (it.opcode == hns_pkg::OP_PIXEL) begin
      if (draining) return;
      c = cur_col;
      r = cur_row;
      if (c >= w || r >= h) begin
        restart_frame();
        c = 0;
        r = 0;
      end
      if (r == 0) begin
        middle_line[c] = it.height;
      end else begin
        predict_normal(c, middle_line[c], upper_line[c], r != 1,
                       (c != 0) ? int'(upper_line[c-1]) : 0, c != 0, hv, 1,
                       (c + 1 < w) ? int'(middle_line[c+1]) : 0);
        upper_line[c] = middle_line[c];
        middle_line[c] = it.height;
      end
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) begin
          r = 0;
          draining = 1;
        end
      end
      cur_col = c;
      cur_row = r;
    end else begin
      if (!draining) return;
      if (emit_pos < (h - 1) * w || emit_pos >= h * w) begin
        restart_frame();
        return;
      end
      c = emit_pos - (h - 1) * w;
      predict_normal(c, middle_line[c], upper_line[c], h != 1,
                     (c != 0) ? int'(middle_line[c-1]) : 0, c != 0, 0, 0,
                     (c + 1 < w) ? int'(middle_line[c+1]) : 0);
    end
  endfunction

  function void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  initial begin
    fail_count = 0;
    normals_pending = 0;
    row_length_reg = 11'd1024;
    row_count_reg = 11'd1024;
    restart_frame();
  end

  always @(posedge clk) begin
    hns_pkg::out_item_t want;
    if (rst) begin
      row_length_reg = 11'd1024;
      row_count_reg = 11'd1024;
      restart_frame();
      normal_queue.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == hns_pkg::REG_ROW_LENGTH) row_length_reg = pwdata[10:0];
        else row_count_reg = pwdata[10:0];
        restart_frame();
      end
      if (pix_valid && !pix_stall) take_item(pix);
      if (nrm_valid && !nrm_stall) begin
        if (normal_queue.size() == 0) begin
          $display("%0t: unexpected normal, expected none, actual %p", $time, nrm);
          fail_count++;
        end else begin
          want = normal_queue.pop_front();
          check_field("normal_x", want.normal_x, nrm.normal_x);
          check_field("normal_y", want.normal_y, nrm.normal_y);
          check_field("normal_z", want.normal_z, nrm.normal_z);
          check_field("row_index", want.row_index, nrm.row_index);
          check_field("column_index", want.column_index, nrm.column_index);
          check_field("frame_last", want.frame_last, nrm.frame_last);
        end
      end
    end
    normals_pending = normal_queue.size();
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int IDLE_LIMIT = 5000;  // cycles with no handshake at all
  localparam int SETTLE = 30;        // wait after the last expected normal

  logic               clk;
  logic               rst;
  logic               pix_valid;
  logic               pix_stall;
  hns_pkg::in_item_t  pix;
  logic               nrm_valid;
  logic               nrm_stall;
  hns_pkg::out_item_t nrm;
  logic               psel, penable, pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  int                 fail_count;
  int                 normals_pending;

  int          burst_left;
  int          items_sent;
  int          idle_cycles;
  int          stall_mode;
  int          cyc;

  heightmap_normal_stencil u_dut (
    .clk, .rst, .pix_valid, .pix_stall, .pix, .nrm_valid, .nrm_stall, .nrm,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  hns_checker u_chk (
    .clk, .rst, .pix_valid, .pix_stall, .pix, .nrm_valid, .nrm_stall, .nrm,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .normals_pending
  );

  always #2 clk = ~clk;

  // receiver: stall style is re-picked at random (none, light, heavy)
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc % 256 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: nrm_stall <= 1'b0;
      1: nrm_stall <= ($urandom_range(0, 3) == 0);
      default: nrm_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  // watchdog: any handshake resets it
  always @(posedge clk) begin
    if (rst || (pix_valid && !pix_stall) || (nrm_valid && !nrm_stall) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one item; bursts of random length with random gaps between them
  task automatic send(hns_pkg::opcode_t op, logic [7:0] h);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        pix_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    pix_valid <= 1'b1;
    pix <= '{opcode: op, height: h};
    @(posedge clk);
    while (!(pix_valid && !pix_stall)) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // drop valid and let every predicted normal come out
  task automatic drain_wait();
    pix_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (normals_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(logic reg_sel, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_size(int w, int h);
    drain_wait();
    reg_write(hns_pkg::REG_ROW_LENGTH, 32'(w));
    reg_write(hns_pkg::REG_ROW_COUNT, 32'(h));
  endtask

  function automatic int clamp(int v);
    return (v < 1) ? 1 : (v > 1024) ? 1024 : v;
  endfunction

  // one frame of pixels then one row of flush items;
  // style 0 random, 1 gentle slopes, 2 only the extremes
  task automatic frame(int w, int h, int style, bit noise);
    int base;
    base = $urandom_range(0, 255);
    for (int i = 0; i < w * h; i++) begin
      case (style)
        0: send(hns_pkg::OP_PIXEL, 8'($urandom_range(0, 255)));
        1: send(hns_pkg::OP_PIXEL, 8'(base + $urandom_range(0, 6)));
        default: send(hns_pkg::OP_PIXEL, $urandom_range(0, 1) ? 8'hFF : 8'h00);
      endcase
    end
    // a pixel during the drain is dropped
    if (noise) send(hns_pkg::OP_PIXEL, 8'($urandom_range(0, 255)));
    for (int i = 0; i < w; i++) send(hns_pkg::OP_FLUSH, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int w, h, n, pick;
    clk = 0;
    rst = 1;
    pix_valid = 0;
    pix = '0;
    nrm_stall = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    burst_left = 0;
    items_sent = 0;
    idle_cycles = 0;
    stall_mode = 0;
    cyc = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: 1x1 map, all neighbors missing so the sum is zero;
    // a flush outside the drain is dropped
    set_size(1, 1);
    send(hns_pkg::OP_FLUSH, 8'h00);
    send(hns_pkg::OP_PIXEL, 8'hFF);
    send(hns_pkg::OP_FLUSH, 8'h00);
    send(hns_pkg::OP_FLUSH, 8'h00);
    // 1x2: last column with a single column
    set_size(1, 2);
    send(hns_pkg::OP_PIXEL, 8'h00);
    send(hns_pkg::OP_PIXEL, 8'hFF);
    send(hns_pkg::OP_FLUSH, 8'h00);
    // 2x2 with extreme heights and a pixel during the drain
    set_size(2, 2);
    send(hns_pkg::OP_PIXEL, 8'h00);
    send(hns_pkg::OP_PIXEL, 8'hFF);
    send(hns_pkg::OP_PIXEL, 8'hFF);
    send(hns_pkg::OP_PIXEL, 8'h00);
    send(hns_pkg::OP_PIXEL, 8'h80);
    send(hns_pkg::OP_FLUSH, 8'hFF);
    send(hns_pkg::OP_FLUSH, 8'h00);
    // 3x2 reaching the last column repeat of the right difference
    set_size(3, 2);
    for (int i = 0; i < 6; i++) send(hns_pkg::OP_PIXEL, (i % 2) ? 8'hFF : 8'h00);
    for (int i = 0; i < 3; i++) send(hns_pkg::OP_FLUSH, 8'h00);

    // zero register values clamp to one
    set_size(0, 0);
    frame(1, 1, 0, 1);

    // random small maps until enough items have gone through
    while (items_sent < 500) begin
      pick = $urandom_range(0, 9);
      w = (pick == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      h = (pick == 1) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      if (pick == 2) w = 0;
      set_size(w, h);
      w = clamp(w);
      h = clamp(h);
      n = $urandom_range(1, 3);
      for (int f = 0; f < n; f++) begin
        if ($urandom_range(0, 4) == 0)
          send(hns_pkg::OP_FLUSH, 8'($urandom_range(0, 255)));
        frame(w, h, $urandom_range(0, 2), $urandom_range(0, 3) == 0);
      end
      // sometimes leave a frame half done; the next register write aborts it
      if ($urandom_range(0, 4) == 0)
        for (int i = $urandom_range(1, w * h); i > 0; i--)
          send(hns_pkg::OP_PIXEL, 8'($urandom_range(0, 255)));
    end

    drain_wait();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/hns_pkg.sv
rtl/hns_quant.sv
rtl/hns_datapath.sv
rtl/hns_ctrl.sv
rtl/heightmap_normal_stencil.sv
test/hns_checker.sv
test/tb_top.sv
